// ===== src/b64_pkg.sv =====
// Shared types, constants and character mapping functions for the Base64 codec.
package b64_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic REG_MODE = 1'b0;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_PAD     = 8'h3d;

  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS       = 6'd62;
  localparam logic [5:0] SX_SLASH      = 6'd63;

  // Group state carried between items
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  count;
    logic        stopped;
  } b64_state_t;

  // Results of one input item, drained one byte per cycle while the receiver is ready
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic            data_valid;
    logic            msg_end;
  } b64_rec_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v < SX_LOWER_BASE) begin
      ch = CH_UPPER_A + {2'b00, v};
    end else if (v < SX_DIGIT_BASE) begin
      ch = CH_LOWER_A + {2'b00, v - SX_LOWER_BASE};
    end else if (v < SX_PLUS) begin
      ch = CH_DIGIT_0 + {2'b00, v - SX_DIGIT_BASE};
    end else if (v == SX_PLUS) begin
      ch = CH_PLUS;
    end else begin
      ch = CH_SLASH;
    end
    return ch;
  endfunction

  // Bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [6:0] sx;
    if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      sx = {1'b0, 6'(c - CH_UPPER_A)};
    end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      sx = {1'b0, 6'(c - CH_LOWER_A) + SX_LOWER_BASE};
    end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
      sx = {1'b0, 6'(c - CH_DIGIT_0) + SX_DIGIT_BASE};
    end else if (c == CH_PLUS) begin
      sx = {1'b0, SX_PLUS};
    end else if (c == CH_SLASH) begin
      sx = {1'b0, SX_SLASH};
    end else begin
      sx = 7'h40;
    end
    return sx;
  endfunction

endpackage

// ===== src/b64_step.sv =====
// Per-item encode/decode logic: next group state and the result bytes of one item.
module b64_step (
  input  logic                mode,
  input  b64_pkg::b64_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                is_last,
  output b64_pkg::b64_state_t st_next,
  output b64_pkg::b64_rec_t   rec,
  output logic                has_out
);
  import b64_pkg::*;

  logic [23:0] enc_sh;
  logic [23:0] enc_v;
  logic [23:0] dec_sh;
  logic [23:0] dec_v;
  logic [1:0]  cnt1;
  logic [6:0]  sx;
  logic [2:0]  n;

  always_comb begin
    st_next = st;
    rec     = '0;
    n       = 3'd0;
    cnt1    = st.count + 2'd1;
    enc_sh  = {st.bits[15:0], in_byte};
    enc_v   = '0;
    sx      = dec_sextet(in_byte);
    dec_sh  = {st.bits[17:0], sx[5:0]};
    dec_v   = '0;

    if (mode == MODE_ENCODE) begin
      if (cnt1 == 2'd3) begin
        rec.data[0] = enc_char(enc_sh[23:18]);
        rec.data[1] = enc_char(enc_sh[17:12]);
        rec.data[2] = enc_char(enc_sh[11:6]);
        rec.data[3] = enc_char(enc_sh[5:0]);
        n = 3'd4;
        st_next.bits  = '0;
        st_next.count = 2'd0;
      end else begin
        st_next.bits  = enc_sh;
        st_next.count = cnt1;
        if (is_last) begin
          // left-align the partial group, pad the rest
          enc_v = (cnt1 == 2'd1) ? {enc_sh[7:0], 16'h0000} : {enc_sh[15:0], 8'h00};
          rec.data[0] = enc_char(enc_v[23:18]);
          rec.data[1] = enc_char(enc_v[17:12]);
          rec.data[2] = (cnt1 == 2'd2) ? enc_char(enc_v[11:6]) : CH_PAD;
          rec.data[3] = CH_PAD;
          n = 3'd4;
        end
      end
    end else begin
      if (!st.stopped) begin
        if (sx[6]) begin
          st_next.stopped = 1'b1;
        end else if (cnt1 == 2'd0) begin
          rec.data[0] = dec_sh[23:16];
          rec.data[1] = dec_sh[15:8];
          rec.data[2] = dec_sh[7:0];
          n = 3'd3;
          st_next.bits  = '0;
          st_next.count = 2'd0;
        end else begin
          st_next.bits  = dec_sh;
          st_next.count = cnt1;
        end
      end
      if (is_last && st_next.count >= 2'd2) begin
        dec_v = (st_next.count == 2'd2) ? {st_next.bits[11:0], 12'h000}
                                        : {st_next.bits[17:0], 6'h00};
        rec.data[0] = dec_v[23:16];
        rec.data[1] = dec_v[15:8];
        n = {1'b0, st_next.count} - 3'd1;
      end
    end

    rec.data_valid = 1'b1;
    if (is_last) begin
      // an end item always yields something; bare marker when no data
      if (n == 3'd0) begin
        n = 3'd1;
        rec.data_valid = 1'b0;
      end
      rec.msg_end = 1'b1;
      st_next     = '0;
    end

    rec.last_idx = 2'(n - 3'd1);
    has_out      = (n != 3'd0);
  end

endmodule

// ===== src/b64_out.sv =====
// Result register and serializer: holds one item's results, sends one per transaction.
module b64_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  b64_pkg::b64_rec_t rec_in,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic [1:0]        m_tuser
);
  import b64_pkg::*;

  b64_rec_t   rec;
  logic       rec_valid;
  logic [1:0] idx;
  logic       at_end;

  assign at_end   = (idx == rec.last_idx);
  assign free     = !rec_valid || (m_tready && at_end);
  assign m_tvalid = rec_valid;
  assign m_tdata  = rec.data[idx];
  assign m_tlast  = at_end;
  assign m_tuser  = {rec.msg_end, rec.data_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      rec_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (rec_valid && m_tready) begin
      if (at_end) begin
        rec_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end
  end

endmodule

// ===== src/base64_stream_codec.sv =====
// Top level of the streaming Base64 codec: input register, group state, mode register.
// Base64 (standard alphabet) codec. codec_mode 0 encodes one byte per input
// transaction into characters, 1 decodes one character per transaction into
// bytes; s_tlast ends a message and flushes the partial group, and every
// result of that item carries m_tuser[1]. An accepted item waits in the input
// register, passes through the combinational encode/decode logic and is loaded
// into the result register, which drives the output directly. The result
// register drains one byte per cycle while m_tready is high; an item yields
// 0 to 4 results. An item that yields none updates the group state at once,
// even while earlier results drain; an item that yields some waits until the
// result register is empty or sends its last transaction. With m_tready high,
// items that yield none or one run at one per cycle, a decoded stream at one
// character per cycle, and an encoded stream is bound by its output of four
// characters per three bytes. Writing codec_mode drops any partial group.
module base64_stream_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // run_last
  output logic [1:0]  m_tuser,   // [0] out_valid, [1] message_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import b64_pkg::*;

  logic       codec_mode;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  b64_state_t st;
  b64_state_t st_next;
  b64_rec_t   rec;
  logic       has_out;
  logic       out_free;
  logic       advance;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_MODE);
  assign prdata    = (paddr == REG_MODE) ? {31'd0, codec_mode} : 32'd0;

  // an item with no results never touches the result register
  assign advance  = in_valid && (out_free || !has_out);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode <= MODE_ENCODE;
    end else if (cfg_write) begin
      codec_mode <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // a mode write restarts the group
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  b64_step u_step (
    .mode    (codec_mode),
    .st      (st),
    .in_byte (in_byte),
    .is_last (in_last),
    .st_next (st_next),
    .rec     (rec),
    .has_out (has_out)
  );

  b64_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && has_out),
    .rec_in   (rec),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== src/b64_checker.sv =====
// Port-level checks on the codec's result stream, bound to the top level.
module b64_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result stream valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1])
    else $error("bare marker not a lone end-of-message result");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tuser))
    else $error("run of results broken before its last");

endmodule

bind base64_stream_codec b64_checker u_b64_checker (.*);

// ===== dv/base64_stream_codec_test.sv =====
// Self-checking testbench for base64_stream_codec: directed and random encode/decode traffic.
`timescale 1ns / 1ps

module base64_stream_codec_test;
  import b64_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 18;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;

  // Standard alphabet, first character in the top byte
  localparam logic [8*64-1:0] B64_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       item_last;
    logic       msg_end;
  } codec_out_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        s_tlast;   // is_last
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] out_byte
  logic        m_tlast;   // run_last
  logic [1:0]  m_tuser;   // [0] out_valid, [1] message_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic        cur_mode;
  logic [23:0] grp_bits;
  logic [1:0]  grp_cnt;
  logic        dec_stopped;
  codec_out_t  codec_results[$];

  int  errors;
  int  items_sent;
  int  results_seen;
  int  cycle_count;
  bit  idling_on;
  bit  hold_req;
  int  hold_left;

  base64_stream_codec dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    return B64_ALPHA[8*(63 - int'(v)) +: 8];
  endfunction

  // Bit 6 flags a code outside the alphabet
  function automatic logic [6:0] char_value(input logic [7:0] ch);
    for (int i = 0; i < 64; i++) begin
      if (B64_ALPHA[8*(63 - i) +: 8] == ch) return {1'b0, 6'(i)};
    end
    return 7'h40;
  endfunction

  function automatic void clear_group();
    grp_bits    = '0;
    grp_cnt     = '0;
    dec_stopped = 1'b0;
  endfunction

  function automatic void add_result(input logic [7:0] d, input logic v, input logic tail);
    codec_out_t r;
    r.data      = d;
    r.has_data  = v;
    r.item_last = 1'b0;
    r.msg_end   = tail;
    codec_results.push_back(r);
  endfunction

  // Advance the codec by one accepted item and queue what it yields
  function automatic void codec_step(input logic [7:0] ch, input logic tail);
    int          n;
    logic [23:0] v;
    logic [6:0]  sx;
    n = 0;
    if (cur_mode == MODE_ENCODE) begin
      grp_bits = {grp_bits[15:0], ch};
      grp_cnt  = grp_cnt + 2'd1;
      if (grp_cnt == 2'd3) begin
        for (int i = 0; i < 4; i++) begin
          add_result(alpha_char(6'(grp_bits >> (18 - 6*i))), 1'b1, tail);
          n++;
        end
        grp_bits = '0;
        grp_cnt  = '0;
      end else if (tail) begin
        v = grp_bits << (8 * (3 - int'(grp_cnt)));
        for (int i = 0; i < 4; i++) begin
          if (i <= int'(grp_cnt)) add_result(alpha_char(6'(v >> (18 - 6*i))), 1'b1, tail);
          else add_result(CH_PAD, 1'b1, tail);
          n++;
        end
      end
    end else begin
      if (!dec_stopped) begin
        sx = char_value(ch);
        if (sx[6]) begin
          dec_stopped = 1'b1;
        end else begin
          grp_bits = {grp_bits[17:0], sx[5:0]};
          grp_cnt  = grp_cnt + 2'd1;
          if (grp_cnt == 2'd0) begin
            add_result(grp_bits[23:16], 1'b1, tail);
            add_result(grp_bits[15:8], 1'b1, tail);
            add_result(grp_bits[7:0], 1'b1, tail);
            n += 3;
            grp_bits = '0;
          end
        end
      end
      if (tail && grp_cnt >= 2'd2) begin
        v = grp_bits << (6 * (4 - int'(grp_cnt)));
        for (int i = 0; i + 1 < int'(grp_cnt); i++) begin
          add_result(8'(v >> (16 - 8*i)), 1'b1, tail);
          n++;
        end
      end
    end
    if (tail) begin
      if (n == 0) begin
        add_result(8'h00, 1'b0, 1'b1);
        n++;
      end
      clear_group();
    end
    if (n > 0) codec_results[codec_results.size() - 1].item_last = 1'b1;
  endfunction

  // Result checker
  always @(posedge clk) begin
    codec_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (codec_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got data %h valid %b last %b end %b",
                 $time, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
      end else begin
        want = codec_results.pop_front();
        if (m_tdata !== want.data || m_tuser[0] !== want.has_data ||
            m_tlast !== want.item_last || m_tuser[1] !== want.msg_end) begin
          errors++;
          $display("%0t: mismatch: expected data %h valid %b last %b end %b, got data %h valid %b last %b end %b",
                   $time, want.data, want.has_data, want.item_last, want.msg_end,
                   m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, codec_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic offer_item(input logic [7:0] ch, input logic tail);
    // idle one cycle at a time so the idle share stays near IDLE_PCT
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= tail;
    do @(posedge clk); while (!s_tready);
    codec_step(ch, tail);
    items_sent++;
  endtask

  task automatic send_message(input byte_q_t msg, input bit mark_end = 1'b1);
    foreach (msg[i]) offer_item(msg[i], mark_end && (i == msg.size() - 1));
  endtask

  // Drop valid, drain every pending result, then let the pipeline go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (codec_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MODE;
    pwdata  <= {31'b0, mode};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = mode;
    clear_group();
  endtask

  task automatic random_encode_msgs(input int count);
    byte_q_t msg;
    int      goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      msg = {};
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
      send_message(msg);
    end
  endtask

  // Mostly well-formed Base64 text, with some noise and broken messages
  task automatic random_decode_msgs(input int count);
    byte_q_t msg;
    int      goal;
    int      k;
    goal = items_sent + count;
    while (items_sent < goal) begin
      msg = {};
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(1, 12);
        repeat (k) msg.push_back(alpha_char(6'($urandom_range(0, 63))));
        if (k % 4 == 2 && $urandom_range(99) < 70) begin
          msg.push_back(CH_PAD);
          msg.push_back(CH_PAD);
        end else if (k % 4 == 3) begin
          msg.push_back(CH_PAD);
        end
        if ($urandom_range(99) < 15)
          msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
      end
      send_message(msg);
    end
  endtask

  task automatic test_encode_directed();
    send_message('{8'h4d});
    send_message('{8'h4d, 8'h61});
    send_message('{8'h4d, 8'h61, 8'h6e});
    send_message('{8'h00, 8'hff, 8'hfb});
  endtask

  // A mode write must drop the half-gathered group
  task automatic test_mode_change_drop();
    send_message('{8'haa, 8'h55}, 1'b0);
    write_mode(MODE_DECODE);
  endtask

  task automatic test_decode_directed();
    send_message('{"T", "W", "E", CH_PAD});
    send_message('{"T"});
    send_message('{CH_PAD});
    // full group, then a high byte stops decoding and the rest is ignored
    send_message('{"+", "/", "9", "a", 8'h80, "z"});
    send_message('{"A", "b", 8'hff});
  endtask

  task automatic test_random_decode();
    write_mode(MODE_DECODE);
    random_decode_msgs(180);
  endtask

  task automatic test_random_encode();
    write_mode(MODE_ENCODE);
    random_encode_msgs(170);
  endtask

  // Hold the output long enough for the input side to back up
  task automatic test_output_hold();
    settle();
    hold_req = 1'b1;
    random_encode_msgs(40);
  endtask

  task automatic test_no_idle();
    write_mode(MODE_DECODE);
    idling_on = 1'b0;
    random_decode_msgs(60);
    settle();
    idling_on = 1'b1;
  endtask

  initial begin
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    cycle_count  = 0;
    idling_on    = 1'b1;
    hold_req     = 1'b0;
    cur_mode     = MODE_ENCODE;
    clear_group();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= REG_MODE;
    pwdata   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_encode_directed();
    test_mode_change_drop();
    test_decode_directed();
    test_random_decode();
    test_random_encode();
    test_output_hold();
    test_no_idle();
    settle();

    $display("Covered %0d input and %0d output transactions across encode and decode modes,",
             items_sent, results_seen);
    $display("with padding, bad characters, mode changes mid-message and a long output hold.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
